@@ hdl/lbc_pkg.sv @@
package lbc_pkg;

	localparam int NumBuffersDefault = 32;

	localparam logic [1:0] OP_GET     = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_PIN     = 2'd2;
	localparam logic [1:0] OP_UNPIN   = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_FREE   = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic [7:0]  dev;
		logic [31:0] blk;
		logic [7:0]  refs;
		logic [31:0] stamp;
	} lbc_entry_t;

	localparam int EntryWidth = $bits(lbc_entry_t);

	typedef struct packed {
		logic load;
		logic rd_scan;
		logic rd_idx;
		logic commit;
	} lbc_cmd_t;

	typedef struct packed {
		logic is_get;
		logic idx_ok;
		logic scan_last;
	} lbc_sts_t;

	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		sat_inc = (v == 8'hFF) ? v : v + 8'd1;
	endfunction

endpackage

@@ hdl/lbc_req_if.sv @@
interface lbc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [7:0]  device_id;
	logic [31:0] block_number;
	logic [4:0]  entry_index;

	modport source (output valid, operation, device_id, block_number, entry_index,
		input ready);
	modport sink (input valid, operation, device_id, block_number, entry_index,
		output ready);
endinterface

@@ hdl/lbc_rsp_if.sv @@
interface lbc_rsp_if;
	logic       valid;
	logic       ready;
	logic [4:0] buffer_index;
	logic       was_hit;
	logic       needs_read;
	logic [1:0] status;

	modport source (output valid, buffer_index, was_hit, needs_read, status,
		input ready);
	modport sink (input valid, buffer_index, was_hit, needs_read, status,
		output ready);
endinterface

@@ hdl/lbc_ram.sv @@
module lbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ hdl/lbc_dpath.sv @@
module lbc_dpath import lbc_pkg::*; #(
	parameter int NUM_BUFFERS = NumBuffersDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  lbc_cmd_t    cmd,
	output lbc_sts_t    sts,
	input  logic [1:0]  operation,
	input  logic [7:0]  device_id,
	input  logic [31:0] block_number,
	input  logic [4:0]  entry_index,
	output logic [4:0]  buffer_index,
	output logic        was_hit,
	output logic        needs_read,
	output logic [1:0]  status
);
	localparam int IW = $clog2(NUM_BUFFERS);

	logic [1:0]  op_q;
	logic [7:0]  dev_q;
	logic [31:0] blk_q;
	logic [4:0]  idx_q;

	logic [IW-1:0]          cnt_q;
	logic                   rd_v_s1;
	logic [IW-1:0]          addr_s1;
	logic [NUM_BUFFERS-1:0] valid_q;
	logic [NUM_BUFFERS-1:0] written_q;
	logic [31:0]            tick_q;

	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	logic          found_q;
	logic [IW-1:0] victim_q;
	logic [31:0]   best_stamp_q;
	lbc_entry_t    sel_ent_q;

	logic [IW-1:0]         ram_raddr;
	logic [EntryWidth-1:0] ram_rdata;
	logic                  ram_we;
	logic [IW-1:0]         ram_waddr;
	lbc_entry_t            ram_wdata;

	lbc_entry_t eff;
	logic       is_get;
	logic       idx_ok;
	logic       tag_match;
	logic       free_better;

	logic       tick_adv;
	logic       mark_valid;
	logic [4:0] res_idx;
	logic       res_hit;
	logic       res_rd;
	logic [1:0] res_st;

	assign is_get = (op_q == OP_GET);
	assign idx_ok = ({27'd0, idx_q} < NUM_BUFFERS);

	assign sts.is_get    = is_get;
	assign sts.idx_ok    = idx_ok;
	assign sts.scan_last = (cnt_q == IW'(NUM_BUFFERS - 1));

	assign ram_raddr = cmd.rd_scan ? cnt_q : IW'(idx_q);

	// write the entry only in the update cycle
	lbc_ram #(
		.WIDTH(EntryWidth),
		.DEPTH(NUM_BUFFERS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we & cmd.commit),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_scan | cmd.rd_idx),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// never-written entries read as the cleared reset value
	assign eff = written_q[addr_s1] ? lbc_entry_t'(ram_rdata) : '0;
	assign tag_match = (eff.dev == dev_q) && (eff.blk == blk_q);
	assign free_better = (eff.refs == 8'd0) && (!found_q || eff.stamp < best_stamp_q);

	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = IW'(idx_q);
		ram_wdata  = sel_ent_q;
		tick_adv   = 1'b0;
		mark_valid = 1'b0;
		res_idx    = idx_q;
		res_hit    = 1'b0;
		res_rd     = 1'b0;
		res_st     = ST_OK;
		if (is_get) begin
			if (hit_q) begin
				ram_we          = 1'b1;
				ram_waddr       = hit_idx_q;
				ram_wdata.refs  = sat_inc(sel_ent_q.refs);
				ram_wdata.stamp = tick_q;
				tick_adv        = 1'b1;
				mark_valid      = 1'b1;
				res_idx         = 5'(hit_idx_q);
				res_hit         = 1'b1;
				res_rd          = !valid_q[hit_idx_q];
			end else if (found_q) begin
				ram_we          = 1'b1;
				ram_waddr       = victim_q;
				ram_wdata.dev   = dev_q;
				ram_wdata.blk   = blk_q;
				ram_wdata.refs  = 8'd1;
				ram_wdata.stamp = tick_q;
				tick_adv        = 1'b1;
				mark_valid      = 1'b1;
				res_idx         = 5'(victim_q);
				res_rd          = 1'b1;
			end else begin
				res_idx = 5'd0;
				res_st  = ST_NO_FREE;
			end
		end else if (idx_ok) begin
			ram_we = 1'b1;
			if (op_q == OP_PIN) begin
				ram_wdata.refs = sat_inc(sel_ent_q.refs);
			end else begin
				if (sel_ent_q.refs == 8'd0) begin
					res_st = ST_UNDERFLOW;
				end else begin
					ram_wdata.refs = sel_ent_q.refs - 8'd1;
				end
				if (op_q == OP_RELEASE) begin
					ram_wdata.stamp = tick_q;
					tick_adv        = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_v_s1   <= 1'b0;
			valid_q   <= '0;
			written_q <= '0;
			tick_q    <= '0;
			hit_q     <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.rd_scan | cmd.rd_idx;
			if (cmd.load) begin
				cnt_q   <= '0;
				hit_q   <= 1'b0;
				found_q <= 1'b0;
			end else if (cmd.rd_scan) begin
				cnt_q <= cnt_q + IW'(1);
			end
			if (rd_v_s1 && is_get) begin
				if (tag_match && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (free_better) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				if (ram_we) begin
					written_q[ram_waddr] <= 1'b1;
				end
				if (mark_valid) begin
					valid_q[ram_waddr] <= 1'b1;
				end
				if (tick_adv) begin
					tick_q <= tick_q + 32'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			dev_q <= device_id;
			blk_q <= block_number;
			idx_q <= entry_index;
		end
		if (cmd.rd_scan | cmd.rd_idx) begin
			addr_s1 <= ram_raddr;
		end
		if (rd_v_s1) begin
			if (!is_get) begin
				sel_ent_q <= eff;
			end else begin
				if (tag_match && !hit_q) begin
					hit_idx_q <= addr_s1;
					sel_ent_q <= eff;
				end
				if (free_better) begin
					victim_q     <= addr_s1;
					best_stamp_q <= eff.stamp;
				end
			end
		end
		if (cmd.commit) begin
			buffer_index <= res_idx;
			was_hit      <= res_hit;
			needs_read   <= res_rd;
			status       <= res_st;
		end
	end

	// the last fetched entry must be compared before the update commits
	a_commit_after_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !rd_v_s1)
		else $error("commit while a fetched entry is still pending");

	a_tick_step: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.commit |=> tick_q == $past(tick_q))
		else $error("tick advanced outside commit");

	a_valid_written: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && mark_valid |=> written_q[$past(ram_waddr)])
		else $error("entry marked valid without being written");

	a_no_scan_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_scan |-> !cmd.commit)
		else $error("write during tag scan");
endmodule

@@ hdl/lbc_ctrl.sv @@
module lbc_ctrl import lbc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	input  lbc_sts_t sts,
	output lbc_cmd_t cmd
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_ISSUE,
		S_WAIT,
		S_COMMIT,
		S_OUT
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   valid_q;

	assign req_ready = ready_q;
	assign rsp_valid = valid_q;

	always_comb begin
		cmd         = '0;
		cmd.load    = (state_q == S_IDLE) && req_valid && ready_q;
		cmd.rd_scan = (state_q == S_ISSUE) && sts.is_get;
		cmd.rd_idx  = (state_q == S_ISSUE) && !sts.is_get && sts.idx_ok;
		cmd.commit  = (state_q == S_COMMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
			valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid && ready_q) begin
						ready_q <= 1'b0;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					if (sts.is_get) begin
						if (sts.scan_last) begin
							state_q <= S_WAIT;
						end
					end else if (sts.idx_ok) begin
						state_q <= S_WAIT;
					end else begin
						state_q <= S_COMMIT;
					end
				end
				S_WAIT: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					valid_q <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					// hold the result until the transfer completes
					if (rsp_ready) begin
						valid_q <= 1'b0;
						ready_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
					valid_q <= 1'b0;
				end
			endcase
		end
	end
endmodule

@@ hdl/lru_block_buffer_cache.sv @@
// Get: one tag RAM read per entry in S_ISSUE, the compare of the last entry in
// S_WAIT, then the update in S_COMMIT, before the result is valid. Release, pin,
// unpin: one indexed read, S_WAIT and S_COMMIT; an index beyond the store skips the
// read and S_WAIT. A new request is taken only after the result transfer, in the
// cycle after it. Reset: per-entry written and valid flags and the tick clear at once;
// no clearing pass, the block takes a request in the first cycle after reset.
module lru_block_buffer_cache import lbc_pkg::*; #(
	parameter int NUM_BUFFERS = NumBuffersDefault
) (
	input logic       clk,
	input logic       arst_n,
	lbc_req_if.sink   req,
	lbc_rsp_if.source rsp
);
	lbc_cmd_t cmd;
	lbc_sts_t sts;

	lbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lbc_dpath #(
		.NUM_BUFFERS(NUM_BUFFERS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.operation    (req.operation),
		.device_id    (req.device_id),
		.block_number (req.block_number),
		.entry_index  (req.entry_index),
		.buffer_index (rsp.buffer_index),
		.was_hit      (rsp.was_hit),
		.needs_read   (rsp.needs_read),
		.status       (rsp.status)
	);
endmodule
